@@ src/tbbfe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbbfe_pkg
// Shared types and constants of the three band beat flash envelope: band
// count, field widths, register indexes and the control and result records
// that pass between the top level and its lanes.
// ----------------------------------------------------------------------------
package tbbfe_pkg;

  // Number of band lanes. Legal range is 1 to 8. Only the first three
  // lanes see a band level from the input item; the others see zero.
  localparam int unsigned BANDS    = 3;
  localparam int unsigned IN_BANDS = 3;

  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned BRIGHT_W = 8;
  localparam int unsigned FAST_W   = 24;   // Q16.8 smoothed level
  localparam int unsigned AVG_W    = 32;   // Q16.16 slow averages
  localparam int unsigned FF_W     = 9;    // Q1.8 fast factor
  localparam int unsigned SF_W     = 17;   // Q1.16 slow factor
  localparam int unsigned RATIO_W  = 12;   // Q4.8 beat ratio

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX = 8'd255;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_DECAY_STEP       = 3'd0,
    CFG_FLOOR_BRIGHTNESS = 3'd1,
    CFG_FAST_FACTOR      = 3'd2,
    CFG_SLOW_FACTOR      = 3'd3,
    CFG_BEAT_RATIO       = 3'd4
  } cfg_idx_e;

  // Configuration as the lanes use it, with factors already clamped to one.
  typedef struct packed {
    logic [BRIGHT_W-1:0] decay_step;
    logic [BRIGHT_W-1:0] floor_brightness;
    logic [FF_W-1:0]     fast_f;
    logic [FF_W-1:0]     fast_f_inv;
    logic [SF_W-1:0]     slow_f;
    logic [SF_W-1:0]     slow_f_inv;
    logic [RATIO_W-1:0]  beat_ratio;
  } cfg_t;

  // Step strobes of the shared sequencer.
  typedef struct packed {
    logic mul;       // form the blend products
    logic sum;       // add and scale the products
    logic thr;       // form the beat threshold product
    logic commit;    // decide beat and envelope, write state
  } ctrl_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0] brightness;
    logic                beat;
    logic                active;
  } band_res_t;

endpackage

`default_nettype wire

@@ src/tbbfe_band_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbbfe_band_lane
// One band: slow average update, fast level filter, beat test and the
// brightness envelope, stepped by the shared sequencer.
// ----------------------------------------------------------------------------
module tbbfe_band_lane (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tbbfe_pkg::ctrl_t              ctrl_i,
  input  wire tbbfe_pkg::cfg_t               cfg_i,
  input  wire logic [tbbfe_pkg::LEVEL_W-1:0] level_i,
  output tbbfe_pkg::band_res_t               res_o
);
  import tbbfe_pkg::*;

  localparam int unsigned SP_W  = AVG_W + SF_W;        // slow products
  localparam int unsigned FP_W  = FAST_W + FF_W;       // fast products
  localparam int unsigned THR_W = AVG_W + RATIO_W;

  logic [FAST_W-1:0]   fast_level_q;
  logic [AVG_W-1:0]    slow_avg_q;
  logic [BRIGHT_W-1:0] bright_q;
  logic                active_q;

  logic [SP_W-1:0]     slow_p_new_q, slow_p_old_q;
  logic [FP_W-1:0]     fast_p_new_q, fast_p_old_q;
  logic [AVG_W-1:0]    avg_new_q;
  logic [FAST_W-1:0]   lvl_new_q;
  logic [THR_W-1:0]    thr_q;

  logic [SP_W:0]       slow_sum;
  logic [FP_W:0]       fast_sum;
  logic                beat;
  logic [BRIGHT_W-1:0] base;
  logic [BRIGHT_W:0]   diff;
  logic                clamp;
  logic [BRIGHT_W-1:0] bright_d;
  logic                active_d;

  assign slow_sum = {1'b0, slow_p_new_q} + {1'b0, slow_p_old_q};
  assign fast_sum = {1'b0, fast_p_new_q} + {1'b0, fast_p_old_q};

  // Beat when level * 2^16 is strictly above average * ratio.
  assign beat  = {{(THR_W-FAST_W-16){1'b0}}, lvl_new_q, 16'd0} > thr_q;
  assign base  = beat ? BRIGHT_MAX : bright_q;
  assign diff  = {1'b0, base} - {1'b0, cfg_i.decay_step};
  // A borrow means the difference went negative, which is below any floor.
  assign clamp = diff[BRIGHT_W] || (diff[BRIGHT_W-1:0] < cfg_i.floor_brightness);

  always_comb begin
    if (clamp) begin
      bright_d = cfg_i.floor_brightness;
      active_d = 1'b0;
    end else begin
      bright_d = diff[BRIGHT_W-1:0];
      active_d = beat | active_q;
    end
  end

  assign res_o.brightness = bright_d;
  assign res_o.beat       = beat;
  assign res_o.active     = active_d;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      slow_p_new_q <= SP_W'({fast_level_q, 8'd0} * cfg_i.slow_f);
      slow_p_old_q <= SP_W'(slow_avg_q * cfg_i.slow_f_inv);
      fast_p_new_q <= FP_W'({level_i, 8'd0} * cfg_i.fast_f);
      fast_p_old_q <= FP_W'(fast_level_q * cfg_i.fast_f_inv);
    end
    if (ctrl_i.sum) begin
      avg_new_q <= slow_sum[AVG_W+16-1:16];
      lvl_new_q <= fast_sum[FAST_W+8-1:8];
    end
    if (ctrl_i.thr) begin
      thr_q <= THR_W'(avg_new_q * cfg_i.beat_ratio);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_level_q <= '0;
      slow_avg_q   <= '0;
      bright_q     <= '0;
      active_q     <= 1'b0;
    end else if (ctrl_i.commit) begin
      fast_level_q <= lvl_new_q;
      slow_avg_q   <= avg_new_q;
      bright_q     <= bright_d;
      active_q     <= active_d;
    end
  end

endmodule

`default_nettype wire

@@ src/tbbfe_freq_avg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tbbfe_freq_avg
// Slow exponential average of the dominant frequency, Q16.16.
// ----------------------------------------------------------------------------
module tbbfe_freq_avg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire tbbfe_pkg::ctrl_t             ctrl_i,
  input  wire tbbfe_pkg::cfg_t              cfg_i,
  input  wire logic [tbbfe_pkg::FREQ_W-1:0] peak_i,
  output logic [tbbfe_pkg::FREQ_W-1:0]      avg_o
);
  import tbbfe_pkg::*;

  localparam int unsigned SP_W = AVG_W + SF_W;

  logic [AVG_W-1:0] avg_q;
  logic [AVG_W-1:0] avg_new_q;
  logic [SP_W-1:0]  p_new_q, p_old_q;
  logic [SP_W:0]    sum;

  assign sum   = {1'b0, p_new_q} + {1'b0, p_old_q};
  assign avg_o = avg_new_q[AVG_W-1:AVG_W-FREQ_W];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      p_new_q <= SP_W'({peak_i, 16'd0} * cfg_i.slow_f);
      p_old_q <= SP_W'(avg_q * cfg_i.slow_f_inv);
    end
    if (ctrl_i.sum) begin
      avg_new_q <= sum[AVG_W+16-1:16];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (ctrl_i.commit) begin
      avg_q <= avg_new_q;
    end
  end

endmodule

`default_nettype wire

@@ src/three_band_beat_flash_envelope.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// three_band_beat_flash_envelope
// Beat detector and flash envelope for low, mid and high spectrum bands.
// ----------------------------------------------------------------------------
// Each input item is one spectrum frame and yields exactly one result item.
// After an item is accepted, the chain of registered multiplies in each
// band lane works it through its steps (blend products, blend sums,
// threshold product, then the beat and envelope decision); the block takes
// no new item until the last step of the current one is done. The
// three band lanes and the frequency averager run side by side, and the
// output register merges their findings into one result item. A finished
// result waits in the output register while the next item is accepted and
// worked on; only its final state write waits for the output register to
// free up. Configuration is written through cfg_we_i, cfg_addr_i and
// cfg_wdata_i and must only change while no item is in flight. Fast factors
// above 256 and slow factors above 65536 act as one.
// ----------------------------------------------------------------------------
module three_band_beat_flash_envelope (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Item in.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // low_band [15:0], mid_band [31:16], high_band [47:32],
  // peak_frequency [63:48]
  input  wire logic [tbbfe_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Result out.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // low_brightness [7:0], mid_brightness [15:8], high_brightness [23:16],
  // low_beat [24], mid_beat [25], high_beat [26], low_active [27],
  // mid_active [28], high_active [29], frequency_average [45:30], zero fill
  output logic [tbbfe_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // Configuration writes.
  input  wire logic                             cfg_we_i,
  input  wire logic [tbbfe_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [tbbfe_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import tbbfe_pkg::*;

  typedef enum logic [1:0] {
    STEP_MUL,
    STEP_SUM,
    STEP_THR,
    STEP_COMMIT
  } step_e;

  // Configuration registers.
  logic [BRIGHT_W-1:0] decay_step_q;
  logic [BRIGHT_W-1:0] floor_brightness_q;
  logic [FF_W-1:0]     fast_factor_q;
  logic [SF_W-1:0]     slow_factor_q;
  logic [RATIO_W-1:0]  beat_ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_step_q       <= 8'd20;
      floor_brightness_q <= 8'd30;
      fast_factor_q      <= 9'd205;
      slow_factor_q      <= 17'd393;
      beat_ratio_q       <= 12'd307;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_DECAY_STEP:       decay_step_q       <= cfg_wdata_i[BRIGHT_W-1:0];
        CFG_FLOOR_BRIGHTNESS: floor_brightness_q <= cfg_wdata_i[BRIGHT_W-1:0];
        CFG_FAST_FACTOR:      fast_factor_q      <= cfg_wdata_i[FF_W-1:0];
        CFG_SLOW_FACTOR:      slow_factor_q      <= cfg_wdata_i[SF_W-1:0];
        CFG_BEAT_RATIO:       beat_ratio_q       <= cfg_wdata_i[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the weights to one and form their complements once for all lanes.
  cfg_t cfg;
  always_comb begin
    cfg.decay_step       = decay_step_q;
    cfg.floor_brightness = floor_brightness_q;
    cfg.fast_f           = (fast_factor_q > 9'd256) ? 9'd256 : fast_factor_q;
    cfg.fast_f_inv       = 9'd256 - cfg.fast_f;
    cfg.slow_f           = (slow_factor_q > 17'd65536) ? 17'd65536 : slow_factor_q;
    cfg.slow_f_inv       = 17'd65536 - cfg.slow_f;
    cfg.beat_ratio       = beat_ratio_q;
  end

  // Sequencer: one item at a time, four steps each.
  logic                 busy_q;
  step_e                step_q;
  logic [IN_DATA_W-1:0] in_q;
  logic                 out_free;
  logic                 in_fire;
  ctrl_t                ctrl;

  assign s_axis_tready = !busy_q;
  assign in_fire       = s_axis_tvalid && !busy_q;
  // The commit may only happen when the output register can take the result.
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    ctrl.mul    = busy_q && (step_q == STEP_MUL);
    ctrl.sum    = busy_q && (step_q == STEP_SUM);
    ctrl.thr    = busy_q && (step_q == STEP_THR);
    ctrl.commit = busy_q && (step_q == STEP_COMMIT) && out_free;
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_MUL;
    end else if (in_fire) begin
      busy_q <= 1'b1;
      step_q <= STEP_MUL;
    end else if (busy_q) begin
      unique case (step_q)
        STEP_MUL:    step_q <= STEP_SUM;
        STEP_SUM:    step_q <= STEP_THR;
        STEP_THR:    step_q <= STEP_COMMIT;
        STEP_COMMIT: begin
          if (out_free) begin
            busy_q <= 1'b0;
            step_q <= STEP_MUL;
          end
        end
        default:     step_q <= STEP_MUL;
      endcase
    end
  end

  // Band lanes. Lanes past the third see a zero level.
  band_res_t lane_res [BANDS];

  for (genvar i = 0; i < BANDS; i++) begin : g_lane
    logic [LEVEL_W-1:0] level;
    if (i < IN_BANDS) begin : g_fed
      assign level = in_q[i*LEVEL_W +: LEVEL_W];
    end else begin : g_zero
      assign level = '0;
    end

    tbbfe_band_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .cfg_i   (cfg),
      .level_i (level),
      .res_o   (lane_res[i])
    );
  end

  logic [FREQ_W-1:0] freq_avg;

  tbbfe_freq_avg u_freq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .cfg_i  (cfg),
    .peak_i (in_q[IN_BANDS*LEVEL_W +: FREQ_W]),
    .avg_o  (freq_avg)
  );

  // Merge the lane results into one result item. A band without a lane
  // reports zeros.
  band_res_t shown [IN_BANDS];
  for (genvar i = 0; i < IN_BANDS; i++) begin : g_show
    if (i < BANDS) begin : g_have
      assign shown[i] = lane_res[i];
    end else begin : g_none
      assign shown[i] = '0;
    end
  end

  logic [OUT_DATA_W-1:0] out_d;
  always_comb begin
    out_d = '0;
    for (int i = 0; i < IN_BANDS; i++) begin
      out_d[i*BRIGHT_W +: BRIGHT_W]         = shown[i].brightness;
      out_d[IN_BANDS*BRIGHT_W + i]          = shown[i].beat;
      out_d[IN_BANDS*(BRIGHT_W+1) + i]      = shown[i].active;
    end
    out_d[IN_BANDS*(BRIGHT_W+2) +: FREQ_W] = freq_avg;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.commit) begin
      m_axis_tdata <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (ctrl.commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_three_band_beat_flash_envelope.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_three_band_beat_flash_envelope
// Self-checking testbench of the three band beat flash envelope. Frames go
// in on the slave stream and results come out on the master stream. A
// behavioral copy of the filters, the beat test and the flash envelope
// predicts every result, and a checker compares each result field by field.
// Directed frames and register settings come first, random ones after them.
// ----------------------------------------------------------------------------
module tb_three_band_beat_flash_envelope;
  import tbbfe_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  // Idle time after the last result has come out, before a register write
  // or the end of the run.
  localparam int unsigned SETTLE_CYCLES  = 10;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned MAX_REPORTS    = 100;
  localparam int unsigned OUT_BANDS      = 3;

  // Register values after reset.
  localparam int unsigned DEF_DECAY = 20;
  localparam int unsigned DEF_FLOOR = 30;
  localparam int unsigned DEF_FAST  = 205;
  localparam int unsigned DEF_SLOW  = 393;
  localparam int unsigned DEF_RATIO = 307;

  // Register indexes that the block does not decode.
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_C = 3'd7;

  // One spectrum frame, laid out as it travels in s_axis_tdata.
  typedef struct packed {
    logic [FREQ_W-1:0]  peak_frequency;
    logic [LEVEL_W-1:0] high_band;
    logic [LEVEL_W-1:0] mid_band;
    logic [LEVEL_W-1:0] low_band;
  } band_frame_t;

  // One predicted result; index 0 is the low band.
  typedef struct packed {
    logic [FREQ_W-1:0]                   freq_avg;
    logic [OUT_BANDS-1:0]                active;
    logic [OUT_BANDS-1:0]                beat;
    logic [OUT_BANDS-1:0][BRIGHT_W-1:0]  bright;
  } flash_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  three_band_beat_flash_envelope dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Results that the envelope model has produced and the block still owes.
  flash_result_t expected_q [$];
  int unsigned   mismatch_count;

  // Random idling on both streams; the last test turns it off.
  bit          idle_en;
  // Each increment asks the result sink for one long hold-off.
  int unsigned stall_req_count;
  int unsigned stall_seen_count;

  string band_names [OUT_BANDS] = '{"low", "mid", "high"};

  // Shadow registers, as written through the configuration port.
  logic [BRIGHT_W-1:0] decay_step_q;
  logic [BRIGHT_W-1:0] floor_q;
  logic [FF_W-1:0]     fast_factor_q;
  logic [SF_W-1:0]     slow_factor_q;
  logic [RATIO_W-1:0]  beat_ratio_q;

  // Model state of the filters and the envelopes.
  logic [FAST_W-1:0]   lvl_fast_q [BANDS];
  logic [AVG_W-1:0]    avg_slow_q [BANDS];
  logic [BRIGHT_W-1:0] bright_q   [BANDS];
  logic                active_q   [BANDS];
  logic [AVG_W-1:0]    freq_avg_q;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // A hung handshake ends the run here.
  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Envelope model
  // --------------------------------------------------------------------------

  task automatic reset_model();
    decay_step_q  = BRIGHT_W'(DEF_DECAY);
    floor_q       = BRIGHT_W'(DEF_FLOOR);
    fast_factor_q = FF_W'(DEF_FAST);
    slow_factor_q = SF_W'(DEF_SLOW);
    beat_ratio_q  = RATIO_W'(DEF_RATIO);
    for (int i = 0; i < BANDS; i++) begin
      lvl_fast_q[i] = '0;
      avg_slow_q[i] = '0;
      bright_q[i]   = '0;
      active_q[i]   = 1'b0;
    end
    freq_avg_q = '0;
  endtask

  // Slow Q16.16 average: the new value is weighted by the slow factor, which
  // saturates at one, and the sum is truncated back to Q16.16.
  function automatic logic [AVG_W-1:0] slow_blend_q16(input logic [63:0] fresh_q16,
                                                      input logic [AVG_W-1:0] old);
    logic [63:0] s;
    logic [63:0] sum;
    s   = (slow_factor_q > 65536) ? 64'd65536 : 64'(slow_factor_q);
    sum = fresh_q16 * s + 64'(old) * (64'd65536 - s);
    return sum[47:16];
  endfunction

  // Advances the model by one frame and returns the result it causes.
  task automatic advance_envelope(input band_frame_t fr, output flash_result_t res);
    logic [63:0]        f_eff;
    logic [63:0]        x;
    logic [63:0]        lvl;
    logic [63:0]        level_q32;
    logic [63:0]        threshold;
    logic               beat_now;
    int                 dimmed;
    logic [LEVEL_W-1:0] band_in [IN_BANDS];
    band_in[0] = fr.low_band;
    band_in[1] = fr.mid_band;
    band_in[2] = fr.high_band;
    f_eff = (fast_factor_q > 256) ? 64'd256 : 64'(fast_factor_q);
    freq_avg_q = slow_blend_q16(64'(fr.peak_frequency) << 16, freq_avg_q);
    res = '0;
    for (int i = 0; i < BANDS; i++) begin
      x = (i < IN_BANDS) ? 64'(band_in[i]) : 64'd0;
      // The average takes in the previous smoothed level before it moves.
      avg_slow_q[i] = slow_blend_q16(64'(lvl_fast_q[i]) << 8, avg_slow_q[i]);
      lvl = ((x << 8) * f_eff + 64'(lvl_fast_q[i]) * (64'd256 - f_eff)) >> 8;
      lvl_fast_q[i] = lvl[FAST_W-1:0];
      // Exact comparison of the Q16.8 level against average times ratio.
      level_q32 = 64'(lvl_fast_q[i]) << 16;
      threshold = 64'(avg_slow_q[i]) * 64'(beat_ratio_q);
      beat_now  = (level_q32 > threshold);
      if (beat_now) begin
        bright_q[i] = BRIGHT_MAX;
        active_q[i] = 1'b1;
      end
      // Falling strictly below the floor clamps and ends the flash; landing
      // exactly on it keeps the band active.
      dimmed = int'(bright_q[i]) - int'(decay_step_q);
      if (dimmed < int'(floor_q)) begin
        bright_q[i] = floor_q;
        active_q[i] = 1'b0;
      end else begin
        bright_q[i] = dimmed[BRIGHT_W-1:0];
      end
      if (i < OUT_BANDS) begin
        res.bright[i] = bright_q[i];
        res.beat[i]   = beat_now;
        res.active[i] = active_q[i];
      end
    end
    res.freq_avg = freq_avg_q[AVG_W-1:16];
  endtask

  // --------------------------------------------------------------------------
  // Stream and register drivers
  // --------------------------------------------------------------------------

  // Offers one frame, waits for it to be taken, records the expected result
  // and then maybe pauses. Valid stays high into the next frame when no
  // pause is taken.
  task automatic send_frame(input band_frame_t fr);
    flash_result_t want;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= fr;
    do @(posedge clk_i); while (!s_axis_tready);
    advance_envelope(fr, want);
    expected_q.push_back(want);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // Stops offering frames and waits until every result has come out and
  // the block has had time to settle.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write. The write enable is left high so that writes can
  // follow each other; cfg_close lowers it.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (addr)
      CFG_DECAY_STEP:       decay_step_q  = data[BRIGHT_W-1:0];
      CFG_FLOOR_BRIGHTNESS: floor_q       = data[BRIGHT_W-1:0];
      CFG_FAST_FACTOR:      fast_factor_q = data[FF_W-1:0];
      CFG_SLOW_FACTOR:      slow_factor_q = data[SF_W-1:0];
      CFG_BEAT_RATIO:       beat_ratio_q  = data[RATIO_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drains the block, then writes all five registers.
  task automatic write_settings(input logic [CFG_DATA_W-1:0] decay,
                                input logic [CFG_DATA_W-1:0] floor_level,
                                input logic [CFG_DATA_W-1:0] fast,
                                input logic [CFG_DATA_W-1:0] slow,
                                input logic [CFG_DATA_W-1:0] ratio);
    wait_drained();
    cfg_write(CFG_DECAY_STEP, decay);
    cfg_write(CFG_FLOOR_BRIGHTNESS, floor_level);
    cfg_write(CFG_FAST_FACTOR, fast);
    cfg_write(CFG_SLOW_FACTOR, slow);
    cfg_write(CFG_BEAT_RATIO, ratio);
    cfg_close();
  endtask

  // Sometimes sets the write data bits above a register's width; the block
  // must drop them.
  function automatic logic [CFG_DATA_W-1:0] with_junk(input int unsigned value,
                                                      input int unsigned width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom());
    if (width >= CFG_DATA_W || $urandom_range(0, 3) != 0) return CFG_DATA_W'(value);
    junk = junk & ~((CFG_DATA_W'(1) << width) - CFG_DATA_W'(1));
    return junk | CFG_DATA_W'(value);
  endfunction

  // Mostly settings under which beats come and go, now and then anything
  // the registers can hold.
  task automatic random_setting();
    int unsigned decay;
    int unsigned floor_level;
    int unsigned fast;
    int unsigned slow;
    int unsigned ratio;
    decay       = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40);
    floor_level = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 120);
    fast        = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(20, 256);
    slow        = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                              : $urandom_range(50, 4000);
    ratio       = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : $urandom_range(200, 600);
    write_settings(with_junk(decay, BRIGHT_W), with_junk(floor_level, BRIGHT_W),
                   with_junk(fast, FF_W), with_junk(slow, SF_W),
                   with_junk(ratio, RATIO_W));
  endtask

  // A frame that looks like music: quiet bands with occasional loud hits.
  // One frame in five is plain noise over the whole range instead.
  function automatic band_frame_t music_frame();
    band_frame_t fr;
    logic [LEVEL_W-1:0] lvl [IN_BANDS];
    if ($urandom_range(0, 4) == 0) return band_frame_t'({$urandom(), $urandom()});
    for (int i = 0; i < IN_BANDS; i++) begin
      lvl[i] = ($urandom_range(0, 7) == 0) ? LEVEL_W'($urandom_range(20000, 65535))
                                           : LEVEL_W'($urandom_range(0, 2000));
    end
    fr.low_band       = lvl[0];
    fr.mid_band       = lvl[1];
    fr.high_band      = lvl[2];
    fr.peak_frequency = FREQ_W'($urandom_range(0, 65535));
    return fr;
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------

  // The sink takes results with random bursts of refusal, and on request
  // refuses for a long stretch so that the block backs up into its input.
  initial begin : result_sink
    int unsigned gap_left;
    int unsigned hold_left;
    gap_left         = 0;
    hold_left        = 0;
    stall_seen_count = 0;
    m_axis_tready   <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_req_count != stall_seen_count) begin
        stall_seen_count = stall_req_count;
        hold_left        = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 4) == 0) begin
        gap_left       = $urandom_range(1, 7) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      // Past this many, mismatches are still counted but not printed.
      if (mismatch_count <= MAX_REPORTS)
        $error("%s: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Every result taken from the block is matched against the oldest
  // expected result.
  always @(posedge clk_i) begin : result_check
    flash_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        $error("result item with no frame waiting for it: tdata %0h", m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < OUT_BANDS; i++) begin
          check_field($sformatf("%s_brightness", band_names[i]), 32'(want.bright[i]),
                      32'(m_axis_tdata[BRIGHT_W*i +: BRIGHT_W]));
          check_field($sformatf("%s_beat", band_names[i]), 32'(want.beat[i]),
                      32'(m_axis_tdata[24 + i]));
          check_field($sformatf("%s_active", band_names[i]), 32'(want.active[i]),
                      32'(m_axis_tdata[27 + i]));
        end
        check_field("frequency_average", 32'(want.freq_avg), 32'(m_axis_tdata[45:30]));
        check_field("zero_fill", 32'd0, 32'(m_axis_tdata[OUT_DATA_W-1:46]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings. The first frame decays brightness zero onto the floor;
  // the rest drive each band and the frequency to its extremes.
  task automatic test_first_frames_and_extremes();
    send_frame('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_frame('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_frame('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_frame('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_frame('{16'h8000, 16'h0000, 16'h0000, 16'hFFFF});
    send_frame('{16'h0001, 16'h0000, 16'hFFFF, 16'h0000});
    send_frame('{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000});
    send_frame('{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA});
  endtask

  // A flash that lands exactly on the floor stays active for that frame and
  // is clamped on the next one. Then no decay at all, then the largest.
  task automatic test_floor_landing();
    write_settings(25, 230, DEF_FAST, DEF_SLOW, DEF_RATIO);
    send_frame('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_frame('{16'h1234, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_frame('{16'h1234, 16'h0000, 16'h0000, 16'h0000});
    send_frame('{16'h1234, 16'h0000, 16'h0000, 16'h0000});
    write_settings(0, 0, DEF_FAST, DEF_SLOW, DEF_RATIO);
    send_frame('{16'h4000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_frame('{16'h4000, 16'h0010, 16'h0010, 16'h0010});
    write_settings(255, 255, DEF_FAST, DEF_SLOW, DEF_RATIO);
    send_frame('{16'hC000, 16'h0000, 16'h0000, 16'h0000});
    send_frame('{16'hC000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
  endtask

  // Filter weights at zero, at one and above one, and the ratio at both
  // ends of its range.
  task automatic test_factor_extremes();
    write_settings(DEF_DECAY, DEF_FLOOR, 0, 0, 0);
    send_frame(music_frame());
    write_settings(DEF_DECAY, DEF_FLOOR, 256, 65536, 4095);
    send_frame(music_frame());
    send_frame('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    write_settings(DEF_DECAY, DEF_FLOOR, 511, 131071, 0);
    send_frame(music_frame());
    send_frame('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
  endtask

  // Writes to undecoded indexes must leave every register as it was.
  task automatic test_unknown_register();
    write_settings(DEF_DECAY, DEF_FLOOR, DEF_FAST, DEF_SLOW, DEF_RATIO);
    cfg_write(CFG_SPARE_A, 17'h1FFFF);
    cfg_write(CFG_SPARE_B, 17'h00000);
    cfg_write(CFG_SPARE_C, 17'h15555);
    cfg_close();
    send_frame('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_frame(music_frame());
  endtask

  // Several random settings, each followed by a run of random frames.
  // Some phases run without idling.
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      random_setting();
      idle_en = ($urandom_range(0, 3) != 0);
      repeat (120) send_frame(music_frame());
    end
    idle_en = 1'b1;
  endtask

  // The sink refuses results for a long time while frames keep coming, so
  // the block must hold its input off until the sink takes results again.
  task automatic test_output_stall();
    random_setting();
    stall_req_count++;
    repeat (40) send_frame(music_frame());
  endtask

  // The end of the run streams frames back to back into a sink that never
  // refuses.
  task automatic test_steady_stream();
    random_setting();
    idle_en = 1'b0;
    repeat (200) send_frame(music_frame());
  endtask

  initial begin
    mismatch_count  = 0;
    idle_en         = 1'b1;
    stall_req_count = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= '0;
    cfg_wdata_i   <= '0;
    reset_model();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_frames_and_extremes();
    test_floor_landing();
    test_factor_extremes();
    test_unknown_register();
    test_random_settings();
    test_output_stall();
    test_steady_stream();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      mismatch_count++;
      $error("%0d expected result items never came out", expected_q.size());
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ three_band_beat_flash_envelope.f @@
src/tbbfe_pkg.sv
src/tbbfe_band_lane.sv
src/tbbfe_freq_avg.sv
src/three_band_beat_flash_envelope.sv
dv/tb_three_band_beat_flash_envelope.sv
